@@ design/set_assoc_writeback_lru_cache_macros.svh @@
// Assertion macros used by the cache top level.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_MACROS_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_MACROS_SVH
// Implication checked every clock while out of reset.
`define SALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/salc_pkg.sv @@
// Shared types and constants of the set-associative cache.
package salc_pkg;
    localparam int MAX_WAYS        = 8;
    localparam int MAX_SETS        = 32;
    localparam int MAX_BLOCK_WORDS = 16;
    localparam int ADDR_BITS       = 16;
    localparam int WAY_BITS  = $clog2(MAX_WAYS);
    localparam int SET_BITS  = $clog2(MAX_SETS);
    localparam int OFF_BITS  = $clog2(MAX_BLOCK_WORDS);
    localparam int LINE_BITS = SET_BITS + WAY_BITS;
    localparam int WORD_BITS = LINE_BITS + OFF_BITS;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_PRELOAD = 2'd2;

    localparam logic [2:0] ACT_TO_PROC  = 3'd0;
    localparam logic [2:0] ACT_FROM_PROC = 3'd1;
    localparam logic [2:0] ACT_REFILL   = 3'd2;
    localparam logic [2:0] ACT_WRBACK   = 3'd3;
    localparam logic [2:0] ACT_DROP     = 3'd4;

    localparam logic [1:0] REG_BLOCK_LOG2 = 2'd0;
    localparam logic [1:0] REG_SETS_LOG2  = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] word_address;
        logic signed [31:0] store_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] first_word;
        logic [4:0]  word_count;
        logic signed [31:0] read_value;
        logic        last;
    } t_rsp;
endpackage

@@ design/salc_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module salc_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ design/set_assoc_writeback_lru_cache.sv @@
// Top level: tag/LRU controller of the write-back cache with line and backing memories.
//
// Usage: pulse start with i_req when busy is low. Commands are read, write and
// preload. A preload writes the backing memory in the accepting cycle, yields no
// transfer and leaves busy low. A read or write yields one to three transfers on
// o_rsp, each marked by a one-cycle o_valid pulse, with last set on the final
// one: eviction (write back or drop), refill, then the processor word.
// Sequence, with W the ways in use and B = 2**block_words_log2: the tag scan
// reads the W ways of the set in turn, then the age update rewrites them, and a
// hit then puts out its transfer. A miss adds a refill walk of the B words of the
// line and, when the set is full, an eviction walk of B words before it, which
// runs whether the victim is dirty or clean.
// busy drops in the cycle after the last transfer, so an item occupies the
// block from its accepting edge until then.
// Configuration: busy must be low; i_cfg_we writes register i_cfg_index
// and invalidates every line by a sweep of all 256 tag memory entries, during
// which busy stays high. Reset runs the same sweep.
// The receiver cannot stall: each transfer is valid for exactly one cycle.
module set_assoc_writeback_lru_cache (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  salc_pkg::t_req    i_req,
    output logic              o_valid,
    output salc_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [3:0]        i_cfg_data
);
    localparam int LB = salc_pkg::LINE_BITS;
    localparam int WB = salc_pkg::WORD_BITS;
    localparam int AB = salc_pkg::ADDR_BITS;
    // tag memory entry: valid, dirty, age, tag
    localparam int TW = 1 + 1 + 3 + 16;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCANW = 4'd3;
    localparam logic [3:0] S_EVRD  = 4'd4;
    localparam logic [3:0] S_EVWR  = 4'd5;
    localparam logic [3:0] S_RFRD  = 4'd6;
    localparam logic [3:0] S_RFWR  = 4'd7;
    localparam logic [3:0] S_AGE   = 4'd8;
    localparam logic [3:0] S_AGEW  = 4'd9;
    localparam logic [3:0] S_PROC  = 4'd10;
    localparam logic [3:0] S_PROCW = 4'd11;

    logic [3:0] r_state;
    logic [2:0] r_bw, r_sl;
    logic [3:0] r_ways;
    salc_pkg::t_req r_req;
    logic [LB-1:0] r_clr;
    logic [3:0] r_w;         // scan way counter, wide enough for 8
    logic [3:0] r_hit_w, r_inv_w, r_lru_w;
    logic r_hit, r_inv;
    logic [2:0] r_lru_age;
    logic [3:0] r_old;       // age bound of the touched way, up to 8
    logic [15:0] r_vtag;
    logic r_vdirty;
    logic [4:0] r_i;
    logic [TW-1:0] tag_rd, tag_wd;
    logic tag_we;
    logic [LB-1:0] tag_a;
    logic [31:0] lw_rd, lw_wd, bm_rd, bm_wd;
    logic lw_we, bm_we;
    logic [WB-1:0] lw_a;
    logic [AB-1:0] bm_a;

    logic [15:0] addr, off_mask, set_v, tag_v, line_addr, vaddr, blk;
    logic [3:0] tag_sh;
    logic [4:0] set_i;
    logic [2:0] way;
    logic [LB-1:0] base_line;
    always_comb begin
        addr      = r_req.word_address;
        blk       = 16'd1 << r_bw;
        off_mask  = blk - 16'd1;
        tag_sh    = {1'b0, r_bw} + {1'b0, r_sl};
        set_v     = (addr >> r_bw) & ((16'd1 << r_sl) - 16'd1);
        tag_v     = addr >> tag_sh;
        line_addr = addr & ~off_mask;
        set_i     = set_v[4:0];
        way       = r_hit ? r_hit_w[2:0] : (r_inv ? r_inv_w[2:0] : r_lru_w[2:0]);
        vaddr     = (r_vtag << tag_sh) | (set_v << r_bw);
        base_line = {set_i, way};
    end

    salc_ram #(.AW(LB), .DW(TW)) u_tag (.i_clk(i_clk), .i_we(tag_we), .i_addr(tag_a),
        .i_wdata(tag_wd), .o_rdata(tag_rd));
    salc_ram #(.AW(WB), .DW(32)) u_line (.i_clk(i_clk), .i_we(lw_we), .i_addr(lw_a),
        .i_wdata(lw_wd), .o_rdata(lw_rd));
    salc_ram #(.AW(AB), .DW(32)) u_back (.i_clk(i_clk), .i_we(bm_we), .i_addr(bm_a),
        .i_wdata(bm_wd), .o_rdata(bm_rd));

    logic rv, rd_;
    logic [2:0] ra;
    logic [15:0] rt;
    assign {rv, rd_, ra, rt} = tag_rd;
    logic [3:0] cfg_ways;
    logic [2:0] cfg_bw, cfg_sl;
    always_comb begin
        cfg_bw = (i_cfg_data[2:0] > 3'd4) ? 3'd4 : i_cfg_data[2:0];
        cfg_sl = (i_cfg_data[2:0] > 3'd5) ? 3'd5 : i_cfg_data[2:0];
        cfg_ways = (i_cfg_data == 4'd0) ? 4'd1 : (i_cfg_data > 4'd8 ? 4'd8 : i_cfg_data);
    end

    // memory port drive
    always_comb begin
        tag_we = 1'b0; tag_a = base_line; tag_wd = '0;
        lw_we = 1'b0; lw_a = {base_line, r_i[3:0]}; lw_wd = bm_rd;
        bm_we = 1'b0; bm_a = line_addr + {11'd0, r_i}; bm_wd = lw_rd;
        o_valid = 1'b0; o_rsp = '0;
        case (r_state)
            S_CLR: begin
                tag_we = 1'b1; tag_a = r_clr;
            end
            S_IDLE: begin
                bm_a = i_req.word_address; bm_wd = i_req.store_value;
                bm_we = start && i_req.command == salc_pkg::CMD_PRELOAD;
            end
            S_SCAN, S_SCANW: tag_a = {set_i, r_w[2:0]};
            S_EVRD: begin
                bm_a = vaddr + {11'd0, r_i} - 16'd1;
                bm_we = r_vdirty && r_i != 5'd0;
            end
            S_EVWR: begin
                o_valid = 1'b1;
                o_rsp.action = r_vdirty ? salc_pkg::ACT_WRBACK : salc_pkg::ACT_DROP;
                o_rsp.first_word = vaddr; o_rsp.word_count = blk[4:0] == 5'd0 ? 5'd16 : blk[4:0];
                o_rsp.word_count = (r_bw == 3'd4) ? 5'd16 : blk[4:0];
            end
            S_RFRD: begin
                lw_a = {base_line, r_i[3:0] - 4'd1};
                lw_we = r_i != 5'd0;
            end
            S_RFWR: begin
                o_valid = 1'b1;
                o_rsp.action = salc_pkg::ACT_REFILL; o_rsp.first_word = line_addr;
                o_rsp.word_count = (r_bw == 3'd4) ? 5'd16 : blk[4:0];
            end
            S_AGE, S_AGEW: begin
                tag_a = {set_i, r_w[2:0]};
                tag_we = r_state == S_AGEW;
                if (r_w[2:0] == way) begin
                    tag_wd = {1'b1, (r_req.command == salc_pkg::CMD_WRITE) |
                              (r_hit & rd_), 3'd0, tag_v};
                end else begin
                    tag_wd = {rv, rd_, (rv && {1'b0, ra} < r_old) ? ra + 3'd1 : ra, rt};
                end
            end
            S_PROC: lw_a = {base_line, addr[3:0] & off_mask[3:0]};
            S_PROCW: begin
                lw_a = {base_line, addr[3:0] & off_mask[3:0]};
                lw_wd = r_req.store_value;
                lw_we = r_req.command == salc_pkg::CMD_WRITE;
                o_valid = 1'b1; o_rsp.first_word = addr; o_rsp.word_count = 5'd1;
                o_rsp.last = 1'b1;
                if (r_req.command == salc_pkg::CMD_WRITE) begin
                    o_rsp.action = salc_pkg::ACT_FROM_PROC;
                end else begin
                    o_rsp.action = salc_pkg::ACT_TO_PROC; o_rsp.read_value = lw_rd;
                end
            end
            default: ;
        endcase
    end
    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0;
            r_bw <= 3'd2; r_sl <= 3'd0; r_ways <= 4'd1;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_we && i_cfg_index inside {salc_pkg::REG_BLOCK_LOG2,
                            salc_pkg::REG_SETS_LOG2, salc_pkg::REG_WAYS}) begin
                        case (i_cfg_index)
                            salc_pkg::REG_BLOCK_LOG2: r_bw <= cfg_bw;
                            salc_pkg::REG_SETS_LOG2:  r_sl <= cfg_sl;
                            salc_pkg::REG_WAYS:       r_ways <= cfg_ways;
                            default: ;
                        endcase
                        r_state <= S_CLR; r_clr <= '0;
                    end else if (start && (i_req.command == salc_pkg::CMD_READ ||
                                           i_req.command == salc_pkg::CMD_WRITE)) begin
                        r_req <= i_req; r_w <= '0; r_hit <= 1'b0; r_inv <= 1'b0;
                        r_lru_w <= '0; r_lru_age <= '0; r_state <= S_SCAN;
                    end
                end
                S_SCAN: r_state <= S_SCANW;
                S_SCANW: begin
                    // each way is read in SCAN and evaluated here in SCANW
                    if (rv && rt == tag_v && !r_hit) begin
                        r_hit <= 1'b1; r_hit_w <= r_w; r_old <= {1'b0, ra};
                    end
                    if (!rv && !r_inv) begin r_inv <= 1'b1; r_inv_w <= r_w; end
                    if (r_w == 4'd0 || ra > r_lru_age) begin
                        r_lru_w <= r_w; r_lru_age <= ra; r_vtag <= rt; r_vdirty <= rd_;
                    end
                    if (r_w + 4'd1 == r_ways) begin
                        r_w <= '0; r_i <= '0;
                        if (r_hit || (rv && rt == tag_v)) r_state <= S_AGE;
                        else if (r_inv || !rv) begin
                            r_old <= r_ways; r_state <= S_RFRD;
                        end else begin
                            r_old <= 4'd7; r_state <= S_EVRD;
                        end
                        if (!(r_hit || (rv && rt == tag_v)) && !(r_inv || !rv))
                            r_old <= {1'b0, (r_w == 4'd0 || ra > r_lru_age) ? ra : r_lru_age};
                    end else begin
                        r_w <= r_w + 4'd1; r_state <= S_SCAN;
                    end
                end
                S_EVRD: begin
                    r_i <= r_i + 5'd1;
                    if (r_i == blk[4:0]) begin
                        r_state <= S_EVWR;
                    end
                end
                S_EVWR: begin r_i <= '0; r_state <= S_RFRD; end
                S_RFRD: begin
                    r_i <= r_i + 5'd1;
                    if (r_i == blk[4:0])
                        r_state <= S_RFWR;
                end
                S_RFWR: begin r_w <= '0; r_state <= S_AGE; end
                S_AGE: r_state <= S_AGEW;
                S_AGEW: begin
                    if (r_w + 4'd1 == r_ways) r_state <= S_PROC;
                    else begin r_w <= r_w + 4'd1; r_state <= S_AGE; end
                end
                S_PROC: r_state <= S_PROCW;
                S_PROCW: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "set_assoc_writeback_lru_cache_macros.svh"
    `SALC_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `SALC_ASSERT_IMP(a_last_proc, i_clk, i_rst_n, o_valid && o_rsp.last, r_state == S_PROCW)
    `SALC_ASSERT_NEXT(a_proc_idle, i_clk, i_rst_n, r_state == S_PROCW, !busy)
endmodule
